/* rtl/core/rfvt_pkg.sv */
`timescale 1ns / 1ps
// rfvt_pkg: shared types, codes and extended-precision float helpers for the
// rigid frame vector transform. No dependencies.
package rfvt_pkg;

	localparam int EXP_W = 13;
	localparam int NSTG  = 17;

	typedef enum logic [1:0] {
		K_ZERO = 2'd0,
		K_FIN  = 2'd1,
		K_INF  = 2'd2,
		K_NAN  = 2'd3
	} kind_t;

	typedef logic signed [EXP_W-1:0] xexp_t;

	// Extended value: finite value = sig * 2^(exp-63)
	typedef struct packed {
		kind_t       kind;
		logic        sign;
		xexp_t       exp;
		logic [63:0] sig;
	} xval_t;

	localparam logic [63:0] TOPBIT = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] vec_x;
		logic [31:0] vec_y;
		logic [31:0] vec_z;
	} vec_req_t;

	typedef struct packed {
		logic [31:0] out_x;
		logic [31:0] out_y;
		logic [31:0] out_z;
	} vec_res_t;

	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t REG_FRAME_0  = 3'd0;
	localparam cfg_idx_t REG_FRAME_5  = 3'd5;
	localparam cfg_idx_t REG_PLATFORM = 3'd6;

	localparam logic [1:0] ACT_POS_TO   = 2'd0;
	localparam logic [1:0] ACT_DIR_TO   = 2'd1;
	localparam logic [1:0] ACT_POS_FROM = 2'd2;
	localparam logic [1:0] ACT_DIR_FROM = 2'd3;

	// operand source for one slot of the summation chain
	typedef enum logic [1:0] {
		SEL_P0  = 2'd0,
		SEL_P1  = 2'd1,
		SEL_P2  = 2'd2,
		SEL_ORG = 2'd3
	} sel_t;

	typedef struct packed {
		sel_t s1;
		sel_t s2;
		sel_t s3;
		sel_t s4;
		logic has4;
	} plan_t;

	function automatic xval_t mk(kind_t k, logic s, xexp_t e, logic [63:0] m);
		xval_t r;
		r.kind = k;
		r.sign = s;
		r.exp  = e;
		r.sig  = m;
		return r;
	endfunction

	function automatic xval_t indefinite();
		return mk(K_NAN, 1'b1, '0, 64'hC000_0000_0000_0000);
	endfunction

	function automatic xval_t load32(logic [31:0] b);
		logic        s;
		logic [7:0]  e;
		logic [22:0] m;
		logic [4:0]  sh;
		logic [23:0] mm;
		xval_t       r;
		s  = b[31];
		e  = b[30:23];
		m  = b[22:0];
		sh = '0;
		for (int i = 0; i < 23; i++) begin
			if (m[i]) sh = 5'(23 - i);
		end
		mm = {1'b0, m} << sh;
		if (e == 8'hFF) begin
			if (m == '0) r = mk(K_INF, s, '0, TOPBIT);
			else r = mk(K_NAN, s, '0, {2'b11, m[21:0], 40'b0});
		end else if (e == 8'h00) begin
			if (m == '0) r = mk(K_ZERO, s, '0, '0);
			else r = mk(K_FIN, s, xexp_t'(-126) - xexp_t'({8'b0, sh}), {mm, 40'b0});
		end else begin
			r = mk(K_FIN, s, xexp_t'({5'b0, e}) - xexp_t'(127), {1'b1, m, 40'b0});
		end
		return r;
	endfunction

	function automatic xval_t pick_nan(xval_t a, xval_t b);
		xval_t r;
		if (a.kind != K_NAN) r = b;
		else if (b.kind != K_NAN) r = a;
		else if (a.sig > b.sig) r = a;
		else if (b.sig > a.sig) r = b;
		else if (a.sign != b.sign) r = a.sign ? b : a;
		else r = a;
		return r;
	endfunction

	// nearest-even rounding of a normalized significand to 64 bits
	function automatic xval_t round64(logic s, xexp_t e, logic [63:0] hi, logic rb,
			logic st);
		logic [63:0] h;
		xexp_t       x;
		h = hi;
		x = e;
		if (rb && (st || hi[0])) begin
			h = hi + 64'd1;
			if (h == '0) begin
				h = TOPBIT;
				x = e + xexp_t'(1);
			end
		end
		return mk(K_FIN, s, x, h);
	endfunction

	function automatic logic [31:0] store32(xval_t v);
		logic [31:0]  r;
		logic [6:0]   sh;
		xexp_t        diff;
		logic [127:0] y;
		logic [31:0]  q;
		logic [7:0]   bexp;
		diff = xexp_t'(-126) - v.exp;
		sh   = 7'd40;
		if (v.exp < xexp_t'(-126)) begin
			sh = (diff > xexp_t'(30)) ? 7'd70 : 7'(xexp_t'(40) + diff);
		end
		y = {v.sig, 64'b0} >> sh;
		q = y[95:64];
		if (y[63] && ((|y[62:0]) || q[0])) q = q + 32'd1;
		bexp = 8'(v.exp + xexp_t'(126));
		unique case (v.kind)
			K_ZERO: r = {v.sign, 31'b0};
			K_INF:  r = {v.sign, 8'hFF, 23'b0};
			K_NAN:  r = {v.sign, 8'hFF, v.sig[62:40]};
			default: begin
				if (v.exp > xexp_t'(127)) r = {v.sign, 8'hFF, 23'b0};
				else if (v.exp >= xexp_t'(-126)) r = {v.sign, 31'b0} | (({24'b0, bexp} << 23) + q);
				else r = {v.sign, 31'b0} | q;
			end
		endcase
		return r;
	endfunction

	// association order of the four sum slots per addition order and action
	function automatic plan_t plan(logic order, logic [1:0] act);
		plan_t p;
		p = '{s1: SEL_P0, s2: SEL_P1, s3: SEL_P2, s4: SEL_ORG, has4: 1'b0};
		if (!order) begin
			unique case (act)
				ACT_POS_TO:   p = '{s1: SEL_P2, s2: SEL_P0, s3: SEL_P1, s4: SEL_ORG, has4: 1'b1};
				ACT_DIR_TO:   p = '{s1: SEL_P2, s2: SEL_P0, s3: SEL_P1, s4: SEL_ORG, has4: 1'b0};
				ACT_POS_FROM: p = '{s1: SEL_P2, s2: SEL_P1, s3: SEL_P0, s4: SEL_ORG, has4: 1'b0};
				ACT_DIR_FROM: p = '{s1: SEL_P2, s2: SEL_P0, s3: SEL_P1, s4: SEL_ORG, has4: 1'b0};
			endcase
		end else if (act == ACT_POS_TO) begin
			p = '{s1: SEL_P0, s2: SEL_ORG, s3: SEL_P1, s4: SEL_P2, has4: 1'b1};
		end
		return p;
	endfunction

	function automatic xval_t pick(sel_t s, xval_t p0, xval_t p1, xval_t p2, xval_t o);
		xval_t r;
		unique case (s)
			SEL_P0:  r = p0;
			SEL_P1:  r = p1;
			SEL_P2:  r = p2;
			SEL_ORG: r = o;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/rfvt_fmul.sv */
`timescale 1ns / 1ps
// rfvt_fmul: two-stage exact binary32 x extended multiply, rounded to 64 bits.
// Depends on rfvt_pkg.
module rfvt_fmul (
	input  logic              clk,
	input  logic [1:0]        ld,
	input  rfvt_pkg::xval_t   a,
	input  rfvt_pkg::xval_t   b,
	output rfvt_pkg::xval_t   y
);
	import rfvt_pkg::*;

	typedef struct packed {
		logic        spec;
		xval_t       specv;
		logic        sign;
		xexp_t       exp;
		logic [55:0] plo;
		logic [55:0] phi;
	} mpp_t;

	mpp_t pp_c, pp_s1;
	xval_t res_c;

	always_comb begin
		logic s;
		logic [23:0] m;
		s = a.sign ^ b.sign;
		m = a.sig[63:40];
		pp_c.spec  = 1'b1;
		pp_c.specv = mk(K_ZERO, s, '0, '0);
		if (a.kind == K_NAN || b.kind == K_NAN) begin
			pp_c.specv = pick_nan(a, b);
		end else if (a.kind == K_INF || b.kind == K_INF) begin
			if (a.kind == K_ZERO || b.kind == K_ZERO) pp_c.specv = indefinite();
			else pp_c.specv = mk(K_INF, s, '0, TOPBIT);
		end else if (a.kind != K_ZERO && b.kind != K_ZERO) begin
			pp_c.spec = 1'b0;
		end
		pp_c.sign = s;
		pp_c.exp  = a.exp + b.exp;
		pp_c.plo  = 56'(m) * 56'(b.sig[31:0]);
		pp_c.phi  = 56'(m) * 56'(b.sig[63:32]);
	end

	always_ff @(posedge clk) begin
		if (ld[0]) pp_s1 <= pp_c;
	end

	always_comb begin
		logic [87:0] p;
		p = {32'b0, pp_s1.plo} + {pp_s1.phi, 32'b0};
		if (pp_s1.spec) res_c = pp_s1.specv;
		else if (p[87]) res_c = round64(pp_s1.sign, pp_s1.exp + xexp_t'(1), p[87:24], p[23],
				|p[22:0]);
		else res_c = round64(pp_s1.sign, pp_s1.exp, p[86:23], p[22], |p[21:0]);
	end

	always_ff @(posedge clk) begin
		if (ld[1]) y <= res_c;
	end

endmodule

/* rtl/core/rfvt_fadd.sv */
`timescale 1ns / 1ps
// rfvt_fadd: three-stage extended add/subtract (align, sum, normalize+round).
// Depends on rfvt_pkg.
module rfvt_fadd (
	input  logic              clk,
	input  logic [2:0]        ld,
	input  rfvt_pkg::xval_t   a,
	input  rfvt_pkg::xval_t   b,
	input  logic              neg,
	output rfvt_pkg::xval_t   y
);
	import rfvt_pkg::*;

	typedef struct packed {
		logic        spec;
		xval_t       specv;
		logic        sign;
		logic        esub;
		xexp_t       exp;
		logic [63:0] hi;
		logic [63:0] shi;
		logic [63:0] slo;
	} al_t;

	typedef struct packed {
		logic         spec;
		xval_t        specv;
		logic         zero;
		logic         sign;
		xexp_t        exp;
		logic [127:0] h;
	} sum_t;

	al_t  al_c, al_s1;
	sum_t sm_c, sm_s2;
	xval_t res_c;

	// stage 1: specials, operand swap, alignment with sticky
	always_comb begin
		xval_t bb, big, sml;
		xexp_t d;
		logic [7:0] dc;
		logic [191:0] w;
		bb = b;
		if (neg && b.kind != K_NAN) bb.sign = ~b.sign;
		al_c.spec  = 1'b1;
		al_c.specv = a;
		if (a.kind == K_NAN || bb.kind == K_NAN) al_c.specv = pick_nan(a, bb);
		else if (a.kind == K_INF)
			al_c.specv = (bb.kind == K_INF && a.sign != bb.sign) ? indefinite() : a;
		else if (bb.kind == K_INF) al_c.specv = bb;
		else if (a.kind == K_ZERO)
			al_c.specv = (bb.kind == K_ZERO) ? mk(K_ZERO, a.sign & bb.sign, '0, '0) : bb;
		else if (bb.kind == K_ZERO) al_c.specv = a;
		else al_c.spec = 1'b0;
		if (a.exp > bb.exp || (a.exp == bb.exp && a.sig >= bb.sig)) begin
			big = a;
			sml = bb;
		end else begin
			big = bb;
			sml = a;
		end
		d  = big.exp - sml.exp;
		dc = (d > xexp_t'(128)) ? 8'd128 : d[7:0];
		w  = {sml.sig, 128'b0} >> dc;
		al_c.sign = big.sign;
		al_c.esub = big.sign ^ sml.sign;
		al_c.exp  = big.exp;
		al_c.hi   = big.sig;
		al_c.shi  = w[191:128];
		al_c.slo  = w[127:64] | {63'b0, |w[63:0]};
	end

	always_ff @(posedge clk) begin
		if (ld[0]) al_s1 <= al_c;
	end

	// stage 2: 128-bit add or subtract
	always_comb begin
		logic [128:0] s;
		logic [127:0] dd;
		s  = {1'b0, al_s1.hi, 64'b0} + {1'b0, al_s1.shi, al_s1.slo};
		dd = {al_s1.hi, 64'b0} - {al_s1.shi, al_s1.slo};
		sm_c.spec  = al_s1.spec;
		sm_c.specv = al_s1.specv;
		sm_c.sign  = al_s1.sign;
		sm_c.exp   = al_s1.exp;
		sm_c.zero  = 1'b0;
		if (al_s1.esub) begin
			sm_c.h    = dd;
			sm_c.zero = (dd == '0);
		end else if (s[128]) begin
			sm_c.h   = s[128:1] | {127'b0, s[0]};
			sm_c.exp = al_s1.exp + xexp_t'(1);
		end else begin
			sm_c.h = s[127:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ld[1]) sm_s2 <= sm_c;
	end

	// stage 3: leading-zero normalize and round to 64 bits
	always_comb begin
		logic [6:0] lz;
		logic [127:0] hn;
		lz = '0;
		for (int i = 0; i < 128; i++) begin
			if (sm_s2.h[i]) lz = 7'(127 - i);
		end
		hn = sm_s2.h << lz;
		if (sm_s2.spec) res_c = sm_s2.specv;
		else if (sm_s2.zero) res_c = mk(K_ZERO, 1'b0, '0, '0);
		else res_c = round64(sm_s2.sign, sm_s2.exp - xexp_t'({6'b0, lz}), hn[127:64], hn[63],
				|hn[62:0]);
	end

	always_ff @(posedge clk) begin
		if (ld[2]) y <= res_c;
	end

endmodule

/* rtl/core/rigid_frame_vector_transform_core.sv */
`timescale 1ns / 1ps
// rigid_frame_vector_transform_core: top level, frame registers and the
// 17-stage transform pipeline. Depends on rfvt_pkg, rfvt_fadd, rfvt_fmul.
//
// Moves a binary32 3-vector between a local frame and the world frame. The
// frame (3x3 axis matrix and origin) and the addition-order select sit in
// seven config registers written over the cfg channel, which is always
// ready; write them only while no request is in flight. The pipe has 17
// register stages and the first one loads at the accepting edge. While
// res_ready holds, a new request can enter every cycle, so sustained
// throughput is one vector per clock. The stages are: entry register (1) ->
// origin subtract (3) -> binary32 narrowing (1) -> multiply (2) -> three
// dependent extended adds (3 each) -> binary32 store (1). Each stage holds
// its item until the next one frees up, so a stalled result only blocks the
// pipe once every stage is full; bubbles collapse. All arithmetic is
// 64-bit-significand extended with nearest-even rounding at each step and
// the final result rounded to binary32.
module rigid_frame_vector_transform_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vec_valid,
	output logic                vec_ready,
	input  rfvt_pkg::vec_req_t  vec,
	output logic                res_valid,
	input  logic                res_ready,
	output rfvt_pkg::vec_res_t  res,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  rfvt_pkg::cfg_idx_t  cfg_index,
	input  logic [63:0]         cfg_data
);
	import rfvt_pkg::*;

	// ---------------- config registers ----------------
	logic [63:0] frame_q [6];
	logic        platform_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) frame_q[i] <= '0;
			platform_q <= 1'b0;
		end else if (cfg_valid) begin
			priority if (cfg_index <= REG_FRAME_5) begin
				frame_q[cfg_index] <= cfg_data;
			end else if (cfg_index == REG_PLATFORM) begin
				platform_q <= cfg_data[0];
			end
			// other indexes: ignored
		end
	end

	// unpacked matrix (row-major) and origin; static while requests fly
	xval_t ax [9];
	xval_t ox [3];

	always_comb begin
		for (int k = 0; k < 9; k++) begin
			ax[k] = load32(k[0] ? frame_q[k >> 1][63:32] : frame_q[k >> 1][31:0]);
		end
		for (int i = 0; i < 3; i++) begin
			ox[i] = load32((i[0] == 1'b0) ? frame_q[(9 + i) >> 1][63:32]
					: frame_q[(9 + i) >> 1][31:0]);
		end
	end

	// ---------------- stage control ----------------
	// ld[i]: stage i takes new contents this cycle (it is empty or drains)
	logic [NSTG:1] valid_q;
	logic [NSTG:1] ld;

	always_comb begin
		ld[NSTG] = !valid_q[NSTG] || res_ready;
		for (int i = NSTG - 1; i >= 1; i--) ld[i] = !valid_q[i] || ld[i + 1];
	end

	assign vec_ready = ld[1];
	assign res_valid = valid_q[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ld[1]) valid_q[1] <= vec_valid;
			for (int i = 2; i <= NSTG; i++) begin
				if (ld[i]) valid_q[i] <= valid_q[i - 1];
			end
		end
	end

	// ---------------- datapath ----------------
	logic [1:0] act_s1, act_s2, act_s3, act_s4, act_s5, act_s6, act_s7;
	xval_t v_s1 [3];
	xval_t v_s2 [3];
	xval_t v_s3 [3];
	xval_t v_s4 [3];
	xval_t dif_s4 [3];
	xval_t t_s5 [3];
	xval_t ma [3][3];
	xval_t prod_s7 [3][3];
	xval_t x1 [3];
	xval_t x2 [3];
	xval_t x3 [3];
	xval_t x4 [3];
	xval_t x3_s8 [3];
	xval_t x3_s9 [3];
	xval_t x3_s10 [3];
	xval_t x4_s8 [3];
	xval_t x4_s9 [3];
	xval_t x4_s10 [3];
	xval_t x4_s11 [3];
	xval_t x4_s12 [3];
	xval_t x4_s13 [3];
	xval_t sum1_s10 [3];
	xval_t sum2_s13 [3];
	xval_t sum3_s16 [3];
	xval_t byp_s14 [3];
	xval_t byp_s15 [3];
	xval_t byp_s16 [3];
	logic has4_s8, has4_s9, has4_s10, has4_s11, has4_s12, has4_s13;
	logic has4_s14, has4_s15, has4_s16;
	plan_t pl;
	vec_res_t res_s17;
	logic to_world;

	// stages 2-4: v - origin, one extended subtract per component (used as t by ACT_POS_FROM)
	for (genvar i = 0; i < 3; i++) begin : g_sub
		rfvt_fadd u_sub (
			.clk (clk),
			.ld  (ld[4:2]),
			.a   (v_s1[i]),
			.b   (ox[i]),
			.neg (1'b1),
			.y   (dif_s4[i])
		);
	end

	// matrix operand per product: transpose going to world
	assign to_world = (act_s5 == ACT_POS_TO) || (act_s5 == ACT_DIR_TO);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int k = 0; k < 3; k++) begin
				ma[c][k] = to_world ? ax[3 * k + c] : ax[3 * c + k];
			end
		end
	end

	// stages 6-7: nine products, component c, term k
	for (genvar c = 0; c < 3; c++) begin : g_lane
		for (genvar k = 0; k < 3; k++) begin : g_mul
			rfvt_fmul u_mul (
				.clk (clk),
				.ld  (ld[7:6]),
				.a   (ma[c][k]),
				.b   (t_s5[k]),
				.y   (prod_s7[c][k])
			);
		end

		rfvt_fadd u_add1 (
			.clk (clk),
			.ld  (ld[10:8]),
			.a   (x1[c]),
			.b   (x2[c]),
			.neg (1'b0),
			.y   (sum1_s10[c])
		);

		rfvt_fadd u_add2 (
			.clk (clk),
			.ld  (ld[13:11]),
			.a   (sum1_s10[c]),
			.b   (x3_s10[c]),
			.neg (1'b0),
			.y   (sum2_s13[c])
		);

		rfvt_fadd u_add3 (
			.clk (clk),
			.ld  (ld[16:14]),
			.a   (sum2_s13[c]),
			.b   (x4_s13[c]),
			.neg (1'b0),
			.y   (sum3_s16[c])
		);
	end

	// slot routing for the summation chain
	assign pl = plan(platform_q, act_s7);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			x1[c] = pick(pl.s1, prod_s7[c][0], prod_s7[c][1], prod_s7[c][2], ox[c]);
			x2[c] = pick(pl.s2, prod_s7[c][0], prod_s7[c][1], prod_s7[c][2], ox[c]);
			x3[c] = pick(pl.s3, prod_s7[c][0], prod_s7[c][1], prod_s7[c][2], ox[c]);
			x4[c] = pick(pl.s4, prod_s7[c][0], prod_s7[c][1], prod_s7[c][2], ox[c]);
		end
	end

	// payload and sideband registers; no reset needed
	always_ff @(posedge clk) begin
		if (ld[1]) begin
			act_s1  <= vec.action;
			v_s1[0] <= load32(vec.vec_x);
			v_s1[1] <= load32(vec.vec_y);
			v_s1[2] <= load32(vec.vec_z);
		end
		if (ld[2]) begin
			act_s2 <= act_s1;
			v_s2   <= v_s1;
		end
		if (ld[3]) begin
			act_s3 <= act_s2;
			v_s3   <= v_s2;
		end
		if (ld[4]) begin
			act_s4 <= act_s3;
			v_s4   <= v_s3;
		end
		if (ld[5]) begin
			act_s5 <= act_s4;
			for (int i = 0; i < 3; i++) begin
				if (act_s4 != ACT_POS_FROM) t_s5[i] <= v_s4[i];
				else if (platform_q) t_s5[i] <= load32(store32(dif_s4[i]));
				else t_s5[i] <= dif_s4[i];
			end
		end
		if (ld[6]) act_s6 <= act_s5;
		if (ld[7]) act_s7 <= act_s6;
		if (ld[8]) begin
			x3_s8   <= x3;
			x4_s8   <= x4;
			has4_s8 <= pl.has4;
		end
		if (ld[9]) begin
			x3_s9   <= x3_s8;
			x4_s9   <= x4_s8;
			has4_s9 <= has4_s8;
		end
		if (ld[10]) begin
			x3_s10   <= x3_s9;
			x4_s10   <= x4_s9;
			has4_s10 <= has4_s9;
		end
		if (ld[11]) begin
			x4_s11   <= x4_s10;
			has4_s11 <= has4_s10;
		end
		if (ld[12]) begin
			x4_s12   <= x4_s11;
			has4_s12 <= has4_s11;
		end
		if (ld[13]) begin
			x4_s13   <= x4_s12;
			has4_s13 <= has4_s12;
		end
		if (ld[14]) begin
			byp_s14  <= sum2_s13;
			has4_s14 <= has4_s13;
		end
		if (ld[15]) begin
			byp_s15  <= byp_s14;
			has4_s15 <= has4_s14;
		end
		if (ld[16]) begin
			byp_s16  <= byp_s15;
			has4_s16 <= has4_s15;
		end
		if (ld[17]) begin
			// three-term forms skip the last add
			res_s17.out_x <= store32(has4_s16 ? sum3_s16[0] : byp_s16[0]);
			res_s17.out_y <= store32(has4_s16 ? sum3_s16[1] : byp_s16[1]);
			res_s17.out_z <= store32(has4_s16 ? sum3_s16[2] : byp_s16[2]);
		end
	end

	assign res = res_s17;

	// ---------------- assertions ----------------
	a_accept_on_hole: assert property (@(posedge clk) disable iff (!arst_n)
		!(&valid_q) |-> vec_ready)
		else $error("request refused while a pipeline stage is empty");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&valid_q) && !res_ready |-> !vec_ready)
		else $error("request taken into a full stalled pipeline");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		vec_valid && vec_ready |=> valid_q[1])
		else $error("accepted request missing from first stage");

endmodule
